// ----- rtl/tfkvc_pkg.sv -----
// Shared types and constants of the key/value cache with time-to-live expiry.
// Used by every module of the block but tfkvc_ram; depends on nothing.
package tfkvc_pkg;

  // sizes
  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int TIME_W  = 32;
  localparam int CAP_W   = 5;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ENTRY_W = TIME_W + VALUE_W + KEY_W;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // register indexes (word address bit)
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_EXPIRE   = 1'b1;

  localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(16);
  localparam logic [TIME_W-1:0] EXPIRE_RESET   = '0;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic remove_found;
    logic evict;
    logic clear_all;
    logic write;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
    logic found;
    logic expired;
    logic is_insert;
    logic cap_zero;
    logic over_cap;
  } dp_status_t;

endpackage

// ----- rtl/tfkvc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module tfkvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/tfkvc_datapath.sv -----
// Datapath of the cache: entry RAM, valid bits, order ranks, key scan, result.
// Depends on tfkvc_pkg and tfkvc_ram.
module tfkvc_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tfkvc_pkg::ctrl_cmd_t            cmd,
  output tfkvc_pkg::dp_status_t           status,
  input  logic                            in_operation,
  input  logic [tfkvc_pkg::KEY_W-1:0]     in_lookup_key,
  input  logic [tfkvc_pkg::VALUE_W-1:0]   in_write_value,
  input  logic [tfkvc_pkg::TIME_W-1:0]    in_now_seconds,
  input  logic [tfkvc_pkg::CAP_W-1:0]     cfg_capacity,
  input  logic [tfkvc_pkg::TIME_W-1:0]    cfg_expire,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [tfkvc_pkg::VALUE_W-1:0]   out_read_value,
  output logic [tfkvc_pkg::CNT_W-1:0]     out_entries_in_use
);

  localparam int N = tfkvc_pkg::ENTRIES;
  localparam int IW = tfkvc_pkg::IDX_W;
  localparam int CW = tfkvc_pkg::CNT_W;
  localparam int KW = tfkvc_pkg::KEY_W;
  localparam int VW = tfkvc_pkg::VALUE_W;
  localparam int TW = tfkvc_pkg::TIME_W;
  localparam int MW = tfkvc_pkg::CMP_W;

  // latched word
  logic          op_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] wval_r;
  logic [TW-1:0] now_r;

  // entry state
  logic [N-1:0]  valid_r, valid_nxt;
  logic [IW-1:0] rank_r [N];
  logic [IW-1:0] rank_nxt [N];
  logic [CW-1:0] count_r, count_nxt;

  // scan state
  logic [CW-1:0] scan_idx_r;
  logic [IW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic          found_r;
  logic [IW-1:0] found_idx_r;
  logic [VW-1:0] found_val_r;
  logic          expired_r;

  // result registers
  logic          out_valid_r;
  logic          out_hit_r;
  logic [VW-1:0] out_value_r;
  logic [CW-1:0] out_count_r;

  // ram signals
  logic                                rd_en;
  logic [tfkvc_pkg::ENTRY_W-1:0]       rd_data;
  logic [tfkvc_pkg::ENTRY_W-1:0]       wr_data;
  logic [IW-1:0]                       free_idx;
  logic [KW-1:0]                       ram_key;
  logic [VW-1:0]                       ram_val;
  logic [TW-1:0]                       ram_time;
  logic [TW-1:0]                       age;
  logic                                match;
  logic                                age_over;

  // remove and capacity helpers
  logic          do_rm;
  logic [IW-1:0] rm_rank;
  logic [MW-1:0] cap_ext, cnt_ext, cap_eff;
  logic          res_hit;

  assign rd_en   = cmd.scan && (scan_idx_r < CW'(N));
  assign wr_data = {now_r, wval_r, key_r};
  assign {ram_time, ram_val, ram_key} = rd_data;

  tfkvc_ram #(
    .WIDTH (tfkvc_pkg::ENTRY_W),
    .DEPTH (N)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (cmd.write),
    .wr_addr (free_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx_r[IW-1:0]),
    .rd_data (rd_data)
  );

  // key compare and age check on the word read last cycle
  assign age      = now_r - ram_time;
  assign age_over = (cfg_expire != '0) && (age > cfg_expire);
  assign match    = cmd.scan && cmp_vld_r && valid_r[cmp_idx_r] && (ram_key == key_r);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // effective capacity, clipped to the table size
  assign cap_ext = MW'(cfg_capacity);
  assign cnt_ext = MW'(count_r);
  assign cap_eff = (cap_ext > MW'(N)) ? MW'(N) : cap_ext;

  // removal by rank: the entry at that rank goes, younger ones move up
  assign do_rm   = cmd.remove_found || cmd.evict;
  assign rm_rank = cmd.evict ? '0 : rank_r[found_idx_r];

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (cmd.clear_all) begin
      valid_nxt = '0;
      count_nxt = '0;
    end else if (do_rm) begin
      for (int i = 0; i < N; i++) begin
        if (valid_r[i] && (rank_r[i] == rm_rank)) begin
          valid_nxt[i] = 1'b0;
        end else if (valid_r[i] && (rank_r[i] > rm_rank)) begin
          rank_nxt[i] = rank_r[i] - 1'b1;
        end
      end
      count_nxt = count_r - 1'b1;
    end else if (cmd.write) begin
      valid_nxt[free_idx] = 1'b1;
      rank_nxt[free_idx]  = count_r[IW-1:0];
      count_nxt           = count_r + 1'b1;
    end
  end

  assign res_hit = (op_r == tfkvc_pkg::OP_LOOKUP) && found_r && !expired_r;

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      found_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.load) begin
        found_r   <= 1'b0;
        cmp_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld_r <= rd_en;
        if (match) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      rank_r[i] <= rank_nxt[i];
    end
    if (cmd.load) begin
      op_r       <= in_operation;
      key_r      <= in_lookup_key;
      wval_r     <= in_write_value;
      now_r      <= in_now_seconds;
      scan_idx_r <= '0;
    end else if (cmd.scan) begin
      if (rd_en) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      cmp_idx_r <= scan_idx_r[IW-1:0];
      if (match) begin
        found_idx_r <= cmp_idx_r;
        found_val_r <= ram_val;
        expired_r   <= age_over;
      end
    end
    if (cmd.finish) begin
      out_hit_r   <= res_hit;
      out_value_r <= res_hit ? found_val_r : '0;
      out_count_r <= count_r;
    end
  end

  // status to the controller
  always_comb begin
    status.scan_end  = match || (cmd.scan && cmp_vld_r && (cmp_idx_r == IW'(N - 1)));
    status.found     = found_r;
    status.expired   = expired_r;
    status.is_insert = (op_r == tfkvc_pkg::OP_INSERT);
    status.cap_zero  = (cap_ext == '0);
    status.over_cap  = (cnt_ext >= cap_eff);
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_read_value     = out_value_r;
  assign out_entries_in_use = out_count_r;

endmodule

// ----- rtl/tfkvc_ctrl.sv -----
// Controller of the cache: sequences scan, removal, eviction, write and result.
// Depends on tfkvc_pkg.
module tfkvc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  tfkvc_pkg::dp_status_t status,
  output tfkvc_pkg::ctrl_cmd_t  cmd,
  output logic                  busy
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_DROP  = 7'b0001000,
    S_EVICT = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_end) begin
          state_nxt = status.is_insert ? S_DROP : S_LOOK;
        end
      end
      S_LOOK: begin
        // a stale entry is dropped on the way to a miss
        cmd.remove_found = status.found && status.expired;
        state_nxt        = S_DONE;
      end
      S_DROP: begin
        cmd.remove_found = status.found;
        state_nxt        = S_EVICT;
      end
      S_EVICT: begin
        if (status.cap_zero) begin
          cmd.clear_all = 1'b1;
          state_nxt     = S_DONE;
        end else if (status.over_cap) begin
          cmd.evict = 1'b1;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/ttl_fifo_key_value_cache.sv -----
// Top level of the key/value cache with time-to-live expiry and oldest-first eviction.
// Depends on tfkvc_pkg, tfkvc_ctrl and tfkvc_datapath; holds the register port.
//
// Usage:
//   Command channel: a word (operation, key, value, time) is taken at a clock
//   edge with start high and busy low. busy stays high while it is processed.
//   Result channel: out_valid is high for one cycle with hit, read value and
//   the number of entries in use; the receiver cannot stall, so it must take
//   the word in that cycle.
//   Register port: APB style, capacity_limit at 0x0, expire_seconds at 0x4, to be
//   written by the user only while busy is low (not enforced); pready is always high.
// Sequence:
//   The key search reads the entry RAM one slot per cycle and stops at the
//   match. A lookup then passes S_LOOK and S_DONE; an insert passes S_DROP,
//   S_EVICT (evicting the oldest entry while the count is at or over capacity),
//   S_WRITE and S_DONE; with capacity zero, S_EVICT clears the cache instead and
//   goes to S_DONE. The result strobe comes in the first cycle with busy low.
// Reset:
//   Synchronous, active low: the cache is empty, capacity 16, expiry off.
module ttl_fifo_key_value_cache (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_operation,
  input  logic [tfkvc_pkg::KEY_W-1:0]         in_lookup_key,
  input  logic [tfkvc_pkg::VALUE_W-1:0]       in_write_value,
  input  logic [tfkvc_pkg::TIME_W-1:0]        in_now_seconds,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [tfkvc_pkg::VALUE_W-1:0]       out_read_value,
  output logic [tfkvc_pkg::CNT_W-1:0]         out_entries_in_use,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tfkvc_pkg::ADDR_W-1:0]        paddr,
  input  logic [tfkvc_pkg::DATA_W-1:0]        pwdata,
  output logic [tfkvc_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [tfkvc_pkg::CAP_W-1:0]  cap_r;
  logic [tfkvc_pkg::TIME_W-1:0] expire_r;
  logic                         reg_wr;
  logic                         reg_sel;
  tfkvc_pkg::ctrl_cmd_t         cmd;
  tfkvc_pkg::dp_status_t        status;

  // register port
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= tfkvc_pkg::CAPACITY_RESET;
      expire_r <= tfkvc_pkg::EXPIRE_RESET;
    end else if (reg_wr) begin
      if (reg_sel == tfkvc_pkg::REG_CAPACITY) begin
        cap_r <= pwdata[tfkvc_pkg::CAP_W-1:0];
      end else begin
        expire_r <= pwdata[tfkvc_pkg::TIME_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == tfkvc_pkg::REG_EXPIRE) ? tfkvc_pkg::DATA_W'(expire_r)
                                                     : tfkvc_pkg::DATA_W'(cap_r);

  tfkvc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tfkvc_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_operation       (in_operation),
    .in_lookup_key      (in_lookup_key),
    .in_write_value     (in_write_value),
    .in_now_seconds     (in_now_seconds),
    .cfg_capacity       (cap_r),
    .cfg_expire         (expire_r),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_read_value     (out_read_value),
    .out_entries_in_use (out_entries_in_use)
  );

endmodule

// ----- rtl/tfkvc_checker.sv -----
// Port-level checks of the cache over time, and the bind that attaches them.
// Depends on tfkvc_pkg and the top level ttl_fifo_key_value_cache.
module tfkvc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_hit,
  input logic [tfkvc_pkg::VALUE_W-1:0] out_read_value,
  input logic [tfkvc_pkg::CNT_W-1:0]   out_entries_in_use
);

  // an accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // result strobes never come two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a word in flight");

  // a miss or insert returns a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_read_value == '0)
    else $error("nonzero value on a miss");

  // the count never exceeds the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entries_in_use <= tfkvc_pkg::CNT_W'(tfkvc_pkg::ENTRIES))
    else $error("entry count beyond table size");

endmodule

bind ttl_fifo_key_value_cache tfkvc_checker u_tfkvc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_hit            (out_hit),
  .out_read_value     (out_read_value),
  .out_entries_in_use (out_entries_in_use)
);
